FILE: src/bate_pkg.sv
// shared request codes and compare helper for the bounded array table engine
package bate_pkg;

  localparam logic [3:0] REQ_APPEND     = 4'd0;
  localparam logic [3:0] REQ_INSERT_AT  = 4'd1;
  localparam logic [3:0] REQ_INSERT_SRT = 4'd2;
  localparam logic [3:0] REQ_DELETE_AT  = 4'd3;
  localparam logic [3:0] REQ_GET        = 4'd4;
  localparam logic [3:0] REQ_SET        = 4'd5;
  localparam logic [3:0] REQ_SEARCH     = 4'd6;
  localparam logic [3:0] REQ_MAX        = 4'd7;
  localparam logic [3:0] REQ_MIN        = 4'd8;
  localparam logic [3:0] REQ_SUM        = 4'd9;
  localparam logic [3:0] REQ_REVERSE    = 4'd10;

  localparam logic [4:0] CAP_RESET = 5'd10;

  typedef logic [31:0] word_t;

  // signed less-than on two's complement words
  function automatic logic s_lt(input word_t a, input word_t b);
    s_lt = $signed(a) < $signed(b);
  endfunction

endpackage

FILE: src/bounded_array_table_engine.sv
// bounded array table engine: sequencer around one entry memory
//
//  channel   | ports                                        | handshake
//  ----------+----------------------------------------------+---------------------------
//  request   | in_req_type, in_position, in_operand         | start high while busy low
//  result    | out_result_value .. out_in_order             | out_valid one-cycle strobe
//  config    | psel penable pwrite paddr pwdata prdata      | apb write, pready always 1
//
// one item at a time; the memory has one read and one write port, read data registered
// get answers in GET_V, rejected items in IDLE; max, min, sum, unsorted search scan
// binary search probes in BS_R then BS_C; shifts read then write each moved entry
// reverse swaps pairs; modifying items end in a scan refreshing the in-order flag
// sync active-low reset clears the count and control; memory contents are not cleared
// the receiver cannot stall: each result is shown for exactly one cycle
module bounded_array_table_engine #(
  parameter int DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  // request
  input  logic               start,
  output logic               busy,
  input  logic [3:0]         in_req_type,
  input  logic [4:0]         in_position,
  input  logic signed [31:0] in_operand,
  // result
  output logic               out_valid,
  output logic signed [31:0] out_result_value,
  output logic signed [4:0]  out_found_index,
  output logic               out_done_ok,
  output logic [4:0]         out_entry_count,
  output logic               out_in_order,
  // config
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int CW = $clog2(DEPTH + 1);   // count width
  localparam int AW = $clog2(DEPTH);       // address width
  localparam int PW = (CW > 5) ? CW : 5;   // compare width for positions

  typedef enum logic [4:0] {
    IDLE, SCAN, BS_R, BS_C, SHUP_R, SHUP_W, ISR, ISC,
    DL_V, DL_R, DL_W, GET_V, REV_RA, REV_RB, REV_WA, REV_WB
  } state_t;

  state_t               state_r;
  logic [3:0]           req_r;
  logic [PW-1:0]        pos_r;
  bate_pkg::word_t      key_r;
  logic [CW-1:0]        fill_r;
  logic [4:0]           cap_r;
  logic                 sorted_r;
  logic [CW-1:0]        idx_r;
  logic [CW-1:0]        b_r;
  logic [CW-1:0]        sc_r;
  logic                 pend_r;
  logic signed [CW:0]   lo_r, hi_r;
  logic [CW-1:0]        mid_r;
  logic                 skip_r;
  bate_pkg::word_t      tmp_r, sum_r, mx_r, mn_r, prev_r, val_r;
  logic                 srt_r, fnd_r;
  logic [CW-1:0]        fidx_r;
  logic [4:0]           found_r;
  logic                 ok_r;
  logic                 out_valid_r;

  // entry memory
  bate_pkg::word_t      mem [DEPTH];
  bate_pkg::word_t      rdata_r;
  logic                 rd_en, we;
  logic [AW-1:0]        rd_addr, wa;
  bate_pkg::word_t      wd;

  logic                 accept;
  logic [PW-1:0]        fill_w, cap_w, dep_w, cap_eff;
  logic                 full;
  logic [CW+1:0]        mid_sum;
  logic [CW-1:0]        mid_c;
  logic                 first;

  assign busy    = (state_r != IDLE);
  assign accept  = start && (state_r == IDLE);
  assign fill_w  = PW'(fill_r);
  assign cap_w   = PW'(cap_r);
  assign dep_w   = PW'(DEPTH);
  assign cap_eff = (cap_w > dep_w) ? dep_w : cap_w;
  assign full    = (fill_w >= cap_eff);
  assign mid_sum = (CW+2)'($unsigned(lo_r)) + (CW+2)'($unsigned(hi_r));
  assign mid_c   = mid_sum[CW:1];
  assign first   = (sc_r == CW'(1));

  // apb config port
  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {27'd0, cap_r};

  // memory port control per state
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    we      = 1'b0;
    wa      = '0;
    wd      = key_r;
    unique case (state_r)
      IDLE: begin
        if (accept) begin
          if (in_req_type == bate_pkg::REQ_APPEND && !full) begin
            we = 1'b1;
            wa = AW'(fill_r);
            wd = in_operand;
          end else if (in_req_type == bate_pkg::REQ_SET && PW'(in_position) < fill_w) begin
            we = 1'b1;
            wa = AW'(in_position);
            wd = in_operand;
          end else if ((in_req_type == bate_pkg::REQ_GET ||
                        in_req_type == bate_pkg::REQ_DELETE_AT) &&
                       PW'(in_position) < fill_w) begin
            rd_en   = 1'b1;
            rd_addr = AW'(in_position);
          end
        end
      end
      SCAN: begin
        rd_en   = (sc_r < fill_r);
        rd_addr = AW'(sc_r);
      end
      BS_R: begin
        rd_en   = (lo_r <= hi_r);
        rd_addr = AW'(mid_c);
      end
      SHUP_R: begin
        if (PW'(idx_r) > pos_r) begin
          rd_en   = 1'b1;
          rd_addr = AW'(idx_r - CW'(1));
        end else if (!skip_r) begin
          we = 1'b1;
          wa = AW'(pos_r);
        end
      end
      SHUP_W: begin
        we = 1'b1;
        wa = AW'(idx_r);
        wd = rdata_r;
      end
      ISR: begin
        if (idx_r != '0) begin
          rd_en   = 1'b1;
          rd_addr = AW'(idx_r - CW'(1));
        end else begin
          we = 1'b1;
          wa = '0;
        end
      end
      ISC: begin
        we = 1'b1;
        wa = AW'(idx_r);
        wd = bate_pkg::s_lt(key_r, rdata_r) ? rdata_r : key_r;
      end
      DL_V: ;
      DL_R: begin
        rd_en   = ((idx_r + CW'(1)) < fill_r);
        rd_addr = AW'(idx_r + CW'(1));
      end
      DL_W: begin
        we = 1'b1;
        wa = AW'(idx_r);
        wd = rdata_r;
      end
      GET_V: ;
      REV_RA: begin
        rd_en   = 1'b1;
        rd_addr = AW'(idx_r);
      end
      REV_RB: begin
        rd_en   = 1'b1;
        rd_addr = AW'(b_r);
      end
      REV_WA: begin
        we = 1'b1;
        wa = AW'(idx_r);
        wd = rdata_r;
      end
      REV_WB: begin
        we = 1'b1;
        wa = AW'(b_r);
        wd = tmp_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= IDLE;
      fill_r      <= '0;
      cap_r       <= bate_pkg::CAP_RESET;
      sorted_r    <= 1'b1;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (psel && penable && pwrite && !paddr[2]) begin
        cap_r <= pwdata[4:0];
      end
      unique case (state_r)
        IDLE: begin
          if (accept) begin
            req_r   <= in_req_type;
            pos_r   <= PW'(in_position);
            key_r   <= in_operand;
            ok_r    <= 1'b0;
            val_r   <= '0;
            found_r <= '1;
            sc_r    <= '0;
            pend_r  <= 1'b0;
            sum_r   <= '0;
            srt_r   <= 1'b1;
            fnd_r   <= 1'b0;
            unique case (in_req_type)
              bate_pkg::REQ_APPEND: begin
                if (!full) begin
                  fill_r  <= fill_r + CW'(1);
                  ok_r    <= 1'b1;
                  state_r <= SCAN;
                end else begin
                  out_valid_r <= 1'b1;
                end
              end
              bate_pkg::REQ_INSERT_AT: begin
                if (PW'(in_position) <= fill_w) begin
                  ok_r   <= 1'b1;
                  skip_r <= full && (PW'(in_position) == fill_w);
                  // top of the shift: last entry drops when full
                  if (fill_r == '0) idx_r <= '0;
                  else if (full)    idx_r <= fill_r - CW'(1);
                  else              idx_r <= fill_r;
                  if (!full) fill_r <= fill_r + CW'(1);
                  state_r <= SHUP_R;
                end else begin
                  out_valid_r <= 1'b1;
                end
              end
              bate_pkg::REQ_INSERT_SRT: begin
                if (sorted_r && !full) begin
                  ok_r    <= 1'b1;
                  idx_r   <= fill_r;
                  fill_r  <= fill_r + CW'(1);
                  state_r <= ISR;
                end else begin
                  out_valid_r <= 1'b1;
                end
              end
              bate_pkg::REQ_DELETE_AT: begin
                if (PW'(in_position) < fill_w) begin
                  ok_r    <= 1'b1;
                  state_r <= DL_V;
                end else begin
                  out_valid_r <= 1'b1;
                end
              end
              bate_pkg::REQ_GET: begin
                if (PW'(in_position) < fill_w) begin
                  ok_r    <= 1'b1;
                  state_r <= GET_V;
                end else begin
                  val_r       <= '1;
                  out_valid_r <= 1'b1;
                end
              end
              bate_pkg::REQ_SET: begin
                if (PW'(in_position) < fill_w) begin
                  ok_r    <= 1'b1;
                  state_r <= SCAN;
                end else begin
                  out_valid_r <= 1'b1;
                end
              end
              bate_pkg::REQ_SEARCH: begin
                if (sorted_r) begin
                  lo_r    <= '0;
                  hi_r    <= $signed({1'b0, fill_r}) - (CW+1)'(1);
                  state_r <= BS_R;
                end else begin
                  state_r <= SCAN;
                end
              end
              bate_pkg::REQ_MAX, bate_pkg::REQ_MIN: begin
                if (fill_r != '0) begin
                  state_r <= SCAN;
                end else begin
                  out_valid_r <= 1'b1;
                end
              end
              bate_pkg::REQ_SUM: begin
                ok_r    <= 1'b1;
                state_r <= SCAN;
              end
              bate_pkg::REQ_REVERSE: begin
                ok_r <= 1'b1;
                if (fill_r > CW'(1)) begin
                  idx_r   <= '0;
                  b_r     <= fill_r - CW'(1);
                  state_r <= REV_RA;
                end else begin
                  out_valid_r <= 1'b1;
                end
              end
              default: begin
                out_valid_r <= 1'b1;
              end
            endcase
          end
        end
        SCAN: begin
          // data of the previous read
          if (pend_r) begin
            sum_r  <= sum_r + rdata_r;
            prev_r <= rdata_r;
            if (first) begin
              mx_r <= rdata_r;
              mn_r <= rdata_r;
            end else begin
              if (bate_pkg::s_lt(mx_r, rdata_r)) mx_r <= rdata_r;
              if (bate_pkg::s_lt(rdata_r, mn_r)) mn_r <= rdata_r;
              if (bate_pkg::s_lt(rdata_r, prev_r)) srt_r <= 1'b0;
            end
            if (!fnd_r && rdata_r == key_r) begin
              fnd_r  <= 1'b1;
              fidx_r <= sc_r - CW'(1);
            end
          end
          if (sc_r < fill_r) begin
            sc_r   <= sc_r + CW'(1);
            pend_r <= 1'b1;
          end else begin
            pend_r <= 1'b0;
          end
          if (sc_r >= fill_r && !pend_r) begin
            priority case (req_r)
              bate_pkg::REQ_MAX: begin
                val_r <= mx_r;
                ok_r  <= 1'b1;
              end
              bate_pkg::REQ_MIN: begin
                val_r <= mn_r;
                ok_r  <= 1'b1;
              end
              bate_pkg::REQ_SUM: val_r <= sum_r;
              bate_pkg::REQ_SEARCH: begin
                if (fnd_r) begin
                  found_r <= 5'(fidx_r);
                  ok_r    <= 1'b1;
                end
              end
              default: sorted_r <= srt_r;
            endcase
            out_valid_r <= 1'b1;
            state_r     <= IDLE;
          end
        end
        BS_R: begin
          if (lo_r <= hi_r) begin
            mid_r   <= mid_c;
            state_r <= BS_C;
          end else begin
            out_valid_r <= 1'b1;
            state_r     <= IDLE;
          end
        end
        BS_C: begin
          if (rdata_r == key_r) begin
            found_r     <= 5'(mid_r);
            ok_r        <= 1'b1;
            out_valid_r <= 1'b1;
            state_r     <= IDLE;
          end else begin
            if (bate_pkg::s_lt(rdata_r, key_r)) lo_r <= $signed({1'b0, mid_r}) + (CW+1)'(1);
            else                                hi_r <= $signed({1'b0, mid_r}) - (CW+1)'(1);
            state_r <= BS_R;
          end
        end
        SHUP_R: begin
          if (PW'(idx_r) > pos_r) state_r <= SHUP_W;
          else                    state_r <= SCAN;
        end
        SHUP_W: begin
          idx_r   <= idx_r - CW'(1);
          state_r <= SHUP_R;
        end
        ISR: begin
          if (idx_r != '0) state_r <= ISC;
          else             state_r <= SCAN;
        end
        ISC: begin
          if (bate_pkg::s_lt(key_r, rdata_r)) begin
            idx_r   <= idx_r - CW'(1);
            state_r <= ISR;
          end else begin
            state_r <= SCAN;
          end
        end
        DL_V: begin
          val_r   <= rdata_r;
          idx_r   <= CW'(pos_r);
          state_r <= DL_R;
        end
        DL_R: begin
          if ((idx_r + CW'(1)) < fill_r) begin
            state_r <= DL_W;
          end else begin
            fill_r  <= fill_r - CW'(1);
            state_r <= SCAN;
          end
        end
        DL_W: begin
          idx_r   <= idx_r + CW'(1);
          state_r <= DL_R;
        end
        GET_V: begin
          val_r       <= rdata_r;
          out_valid_r <= 1'b1;
          state_r     <= IDLE;
        end
        REV_RA: state_r <= REV_RB;
        REV_RB: begin
          tmp_r   <= rdata_r;
          state_r <= REV_WA;
        end
        REV_WA: state_r <= REV_WB;
        REV_WB: begin
          idx_r <= idx_r + CW'(1);
          b_r   <= b_r - CW'(1);
          if ((idx_r + CW'(2)) < b_r) state_r <= REV_RA;
          else                        state_r <= SCAN;
        end
        default: state_r <= IDLE;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = $signed(val_r);
  assign out_found_index  = $signed(found_r);
  assign out_done_ok      = ok_r;
  assign out_entry_count  = 5'(fill_r);
  assign out_in_order     = sorted_r;

  // a result is only shown once the engine is back to idle
  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result shown while busy");

  // count never exceeds the storage
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CW'(DEPTH)) else $error("fill count beyond depth");

  // an accepted item either starts work or answers at once
  a_accept_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid)) else $error("item lost");

  // an empty table always reads as in order
  a_empty_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && fill_r == '0) |-> out_in_order) else $error("empty table unsorted");

endmodule

FILE: tb/bounded_array_table_engine_test.sv
// regression bench for the bounded array table engine: random and directed requests
`timescale 1ns / 100ps

module bounded_array_table_engine_test;

  localparam int TBL_DEPTH = 16;
  localparam int STALL_LIMIT = 20000;
  localparam int PH_CAPS [8] = '{16, 31, 17, 3, 10, 1, 16, 8};

  // one predicted result item
  typedef struct {
    bate_pkg::word_t value;
    logic [4:0]      index;
    logic            ok;
    logic [4:0]      count;
    logic            sorted;
  } reply_t;

  // shadow table plus the queue of predicted replies
  class table_board;
    bate_pkg::word_t slots[TBL_DEPTH];
    int              fill;
    int              cap;
    reply_t          pending[$];
    int              errors;

    function void clear();
      fill = 0;
      cap = bate_pkg::CAP_RESET;
      pending.delete();
      errors = 0;
    endfunction

    function bit ascending();
      for (int i = 1; i < fill; i++)
        if (bate_pkg::s_lt(slots[i], slots[i-1])) return 0;
      return 1;
    endfunction

    function int locate(bate_pkg::word_t key);
      int lo;
      int hi;
      int mid;
      if (ascending()) begin
        lo = 0;
        hi = fill - 1;
        while (lo <= hi) begin
          mid = (lo + hi) / 2;
          if (slots[mid] == key) return mid;
          if (bate_pkg::s_lt(slots[mid], key)) lo = mid + 1;
          else hi = mid - 1;
        end
        return -1;
      end
      for (int i = 0; i < fill; i++)
        if (slots[i] == key) return i;
      return -1;
    endfunction

    // predict the reply of one accepted request
    function void note_request(logic [3:0] op, int pos, bate_pkg::word_t x);
      reply_t          r;
      int              ceff;
      bit              full;
      int              top;
      int              f;
      int              k;
      int              a;
      int              b;
      bate_pkg::word_t t;
      ceff = (cap > TBL_DEPTH) ? TBL_DEPTH : cap;
      full = fill >= ceff;
      r.value = '0;
      f = -1;
      r.ok = 0;
      unique case (op)
        bate_pkg::REQ_APPEND: begin
          if (!full) begin
            slots[fill] = x;
            fill++;
            r.ok = 1;
          end
        end
        bate_pkg::REQ_INSERT_AT: begin
          if (pos <= fill) begin
            top = full ? fill - 1 : fill;
            if (fill == 0) top = 0;
            for (int i = top; i > pos; i--) slots[i] = slots[i-1];
            if (!(full && pos == fill)) slots[pos] = x;
            if (!full) fill++;
            r.ok = 1;
          end
        end
        bate_pkg::REQ_INSERT_SRT: begin
          if (ascending() && !full) begin
            k = fill;
            while (k > 0 && bate_pkg::s_lt(x, slots[k-1])) begin
              slots[k] = slots[k-1];
              k--;
            end
            slots[k] = x;
            fill++;
            r.ok = 1;
          end
        end
        bate_pkg::REQ_DELETE_AT: begin
          if (pos < fill) begin
            r.value = slots[pos];
            for (int i = pos; i + 1 < fill; i++) slots[i] = slots[i+1];
            fill--;
            r.ok = 1;
          end
        end
        bate_pkg::REQ_GET: begin
          if (pos < fill) begin
            r.value = slots[pos];
            r.ok = 1;
          end else r.value = '1;
        end
        bate_pkg::REQ_SET: begin
          if (pos < fill) begin
            slots[pos] = x;
            r.ok = 1;
          end
        end
        bate_pkg::REQ_SEARCH: begin
          f = locate(x);
          r.ok = f >= 0;
        end
        bate_pkg::REQ_MAX, bate_pkg::REQ_MIN: begin
          if (fill > 0) begin
            r.value = slots[0];
            for (int i = 1; i < fill; i++)
              if (op == bate_pkg::REQ_MAX ? bate_pkg::s_lt(r.value, slots[i]) :
                                            bate_pkg::s_lt(slots[i], r.value))
                r.value = slots[i];
            r.ok = 1;
          end
        end
        bate_pkg::REQ_SUM: begin
          for (int i = 0; i < fill; i++) r.value = r.value + slots[i];
          r.ok = 1;
        end
        bate_pkg::REQ_REVERSE: begin
          a = 0;
          b = fill - 1;
          while (a < b) begin
            t = slots[a];
            slots[a] = slots[b];
            slots[b] = t;
            a++;
            b--;
          end
          r.ok = 1;
        end
        default: ;
      endcase
      r.index = 5'(f);
      r.count = 5'(fill);
      r.sorted = ascending();
      pending.push_back(r);
    endfunction

    function void check_reply(reply_t got);
      reply_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result item, none predicted");
        return;
      end
      e = pending.pop_front();
      if (got.value !== e.value || got.index !== e.index || got.ok !== e.ok ||
          got.count !== e.count || got.sorted !== e.sorted) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp val %h idx %0d ok %b cnt %0d ord %b / got %h %0d %b %0d %b",
                   e.value, $signed(e.index), e.ok, e.count, e.sorted,
                   got.value, $signed(got.index), got.ok, got.count, got.sorted);
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [3:0]         in_req_type;
  logic [4:0]         in_position;
  logic signed [31:0] in_operand;
  logic               out_valid;
  logic signed [31:0] out_result_value;
  logic signed [4:0]  out_found_index;
  logic               out_done_ok;
  logic [4:0]         out_entry_count;
  logic               out_in_order;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [2:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  table_board board;
  int         idle_pct;   // sender gap chance in percent
  int         stall_cnt;

  bounded_array_table_engine dut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // results are only ever shown for one cycle, so check each strobe
  always @(posedge clk) begin
    reply_t g;
    if (rst_n && out_valid) begin
      g.value = out_result_value;
      g.index = out_found_index;
      g.ok = out_done_ok;
      g.count = out_entry_count;
      g.sorted = out_in_order;
      board.check_reply(g);
    end
  end

  // watchdog: cycles without any accepted item, result or apb access
  always @(posedge clk) begin
    if (!rst_n || out_valid || (start && !busy) || (psel && penable)) stall_cnt <= 0;
    else stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= STALL_LIMIT) begin
      $display("bounded_array_table_engine regression: fail");
      $finish;
    end
  end

  // apb write, setup then access, only while the engine is idle
  task automatic write_capacity(int v);
    @(posedge clk);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= 3'd0;
    pwdata <= 32'(v);
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    board.cap = v & 5'h1f;
  endtask

  // stop requesting, drain results, then idle a while
  task automatic wait_quiet();
    start <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // present one request and hold it until it is taken; start stays high
  // so the next item can follow at once
  task automatic issue(logic [3:0] op, int pos, bate_pkg::word_t x);
    while ($urandom_range(99) < idle_pct) begin
      start <= 0;
      @(posedge clk);
    end
    start <= 1;
    in_req_type <= op;
    in_position <= 5'(pos);
    in_operand <= x;
    @(posedge clk);
    while (busy) @(posedge clk);
    board.note_request(op, pos, x);
  endtask

  function automatic bate_pkg::word_t rand_word();
    unique case ($urandom_range(3))
      0: return bate_pkg::word_t'($urandom_range(20)) - 10;
      1: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      default: return $urandom;
    endcase
  endfunction

  // mostly meaningful requests against the current fill, some out of range
  task automatic random_request();
    logic [3:0] op;
    int         pos;
    op = 4'($urandom_range(15) < 14 ? $urandom_range(10) : $urandom_range(15));
    if ($urandom_range(9) == 0) pos = $urandom_range(31);
    else pos = $urandom_range(board.fill);
    if (op == bate_pkg::REQ_SEARCH && board.fill > 0 && $urandom_range(1))
      issue(op, pos, board.slots[$urandom_range(board.fill - 1)]);
    else
      issue(op, pos, rand_word());
  endtask

  initial begin
    board = new();
    board.clear();
    rst_n = 0;
    start = 0;
    in_req_type = '0;
    in_position = '0;
    in_operand = '0;
    psel = 0;
    penable = 0;
    pwrite = 0;
    paddr = '0;
    pwdata = '0;
    idle_pct = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: empty table corner cases, reset capacity
    issue(bate_pkg::REQ_MAX, 0, 0);
    issue(bate_pkg::REQ_MIN, 0, 0);
    issue(bate_pkg::REQ_GET, 0, 0);
    issue(bate_pkg::REQ_DELETE_AT, 0, 0);
    issue(bate_pkg::REQ_SUM, 0, 0);
    issue(bate_pkg::REQ_REVERSE, 0, 0);
    issue(bate_pkg::REQ_SEARCH, 0, 5);
    issue(bate_pkg::REQ_INSERT_AT, 0, 32'h80000000);
    issue(bate_pkg::REQ_APPEND, 0, 32'h7fffffff);
    issue(bate_pkg::REQ_INSERT_SRT, 0, 0);
    issue(bate_pkg::REQ_SET, 31, 1);
    issue(bate_pkg::REQ_SEARCH, 0, 0);
    issue(4'd11, 0, 0);
    issue(4'd15, 31, 32'hffffffff);
    wait_quiet();
    // tiny capacity: full-table insert drops the tail, append refused
    write_capacity(1);
    issue(bate_pkg::REQ_INSERT_AT, 0, 3);
    issue(bate_pkg::REQ_INSERT_AT, 1, 4);
    issue(bate_pkg::REQ_APPEND, 0, 9);
    issue(bate_pkg::REQ_INSERT_SRT, 0, 9);
    issue(bate_pkg::REQ_REVERSE, 0, 0);
    issue(bate_pkg::REQ_SUM, 0, 0);
    issue(bate_pkg::REQ_GET, 0, 0);
    issue(bate_pkg::REQ_SET, 0, 32'h55555555);
    wait_quiet();

    // random phases over several capacities, extremes included
    for (int ph = 0; ph < 8; ph++) begin
      write_capacity(PH_CAPS[ph]);
      idle_pct = (ph < 3) ? 33 : (ph < 5) ? 47 : 0;
      repeat (50) random_request();
      wait_quiet();
    end
    // drain by deletes after an append refused at capacity zero, then empty once more
    write_capacity(0);
    issue(bate_pkg::REQ_APPEND, 0, 1);
    repeat (20) issue(bate_pkg::REQ_DELETE_AT, 0, 0);
    wait_quiet();

    if (board.errors == 0 && board.pending.size() == 0)
      $display("bounded_array_table_engine regression: pass");
    else
      $display("bounded_array_table_engine regression: fail");
    $finish;
  end

endmodule
